### rtl/scba_pkg.sv
package scba_pkg;

  localparam int NumClasses     = 10;
  localparam int BlocksPerClass = 64;
  localparam int IdxSlots       = 64;
  localparam int IdxW           = 6;
  localparam int ClsW           = 4;
  localparam int HandleW        = ClsW + IdxW;
  localparam int CntW           = 7;
  localparam int BytesW         = 14;
  localparam int UsedW          = 20;
  localparam int SizeW          = 32;
  localparam int FuncW          = 3;
  localparam int MinBlock       = 16;
  localparam int MemDepth       = NumClasses * IdxSlots;

  // per-class limit never exceeds the handle index range
  localparam logic [CntW-1:0] LimitCap =
      CntW'((BlocksPerClass < IdxSlots) ? BlocksPerClass : IdxSlots);
  localparam logic [SizeW-1:0] MaxBytes = SizeW'(MinBlock) << (NumClasses - 1);

  typedef enum logic [FuncW-1:0] {
    FUNC_ALLOC   = 3'd0,
    FUNC_FREE    = 3'd1,
    FUNC_QUERY   = 3'd2,
    FUNC_REALLOC = 3'd3,
    FUNC_RESET   = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO       = 3'd1,
    ST_TOO_LARGE  = 3'd2,
    ST_EXHAUSTED  = 3'd3,
    ST_BAD_HANDLE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_TAKE,
    S_POP,
    S_GIVE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic               stk_we;
    logic [HandleW-1:0] stk_waddr;
    logic [IdxW-1:0]    stk_wdata;
    logic               stk_re;
    logic [HandleW-1:0] stk_raddr;
    logic               bm_we;
    logic [HandleW-1:0] bm_waddr;
    logic               bm_wdata;
    logic               bm_re;
    logic [HandleW-1:0] bm_raddr;
  } mem_req_t;

  function automatic logic [BytesW-1:0] class_bytes(input logic [ClsW-1:0] c);
    return BytesW'(MinBlock) << c;
  endfunction

  // smallest class whose block holds s; caller screens out zero and too large
  function automatic logic [ClsW-1:0] size_class(input logic [SizeW-1:0] s);
    logic [ClsW-1:0] cls;
    cls = ClsW'(NumClasses - 1);
    for (int c = NumClasses - 1; c >= 0; c--) begin
      if (s <= (SizeW'(MinBlock) << c)) cls = ClsW'(c);
    end
    return cls;
  endfunction

endpackage

### rtl/scba_store.sv
module scba_store import scba_pkg::*; (
  input  logic            clk_i,
  input  mem_req_t        req_i,
  output logic [IdxW-1:0] stk_rdata_o,
  output logic            bm_rdata_o
);

  // free stacks, one 64-entry region per class
  logic [IdxW-1:0] stk_mem [MemDepth];
  // allocated flag per block; meaningful only below the class watermark
  logic            bm_mem  [MemDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.stk_we) stk_mem[req_i.stk_waddr] <= req_i.stk_wdata;
    if (req_i.stk_re) stk_rdata_o <= stk_mem[req_i.stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.bm_we) bm_mem[req_i.bm_waddr] <= req_i.bm_wdata;
    if (req_i.bm_re) bm_rdata_o <= bm_mem[req_i.bm_raddr];
  end

endmodule

### rtl/size_class_block_allocator_top.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid / stall   | func, request_size, handle_in
// out     | output    | out_valid / stall  | status, handle_valid, handle_out,
//         |           |                    | block_bytes, bytes_in_use, class_free
// cfg     | input     | cfg_valid / ready  | blocks_per_class
//
// States: EVAL, POP, RESP for alloc from the free stack; EVAL, TAKE, RESP for a realloc into an
// exhausted class; EVAL, TAKE, [POP,] GIVE, RESP for a realloc that moves the block; EVAL, RESP
// otherwise. Set by registered stack and allocated-flag memory reads and the single-port counter file.
// Reset: counters, watermarks and bytes in use clear at once; no memory sweep.
// Output stall holds the result register; the next transaction is still taken
// and runs until its own result is due.
module size_class_block_allocator_top import scba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FuncW-1:0]   in_func_i,
  input  logic [SizeW-1:0]   in_request_size_i,
  input  logic [HandleW-1:0] in_handle_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_status_o,
  output logic               out_handle_valid_o,
  output logic [HandleW-1:0] out_handle_out_o,
  output logic [BytesW-1:0]  out_block_bytes_o,
  output logic [UsedW-1:0]   out_bytes_in_use_o,
  output logic [CntW-1:0]    out_class_free_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CntW-1:0]    cfg_data_i
);

  state_e state_q, state_d;

  logic [CntW-1:0]    cfg_q;
  logic [CntW-1:0]    depth_q [NumClasses];
  logic [CntW-1:0]    depth_d [NumClasses];
  logic [CntW-1:0]    wm_q    [NumClasses];
  logic [CntW-1:0]    wm_d    [NumClasses];
  logic [UsedW-1:0]   used_q, used_d;

  logic [FuncW-1:0]   func_q, func_d;
  logic               zero_q, zero_d;
  logic               big_q, big_d;
  logic [ClsW-1:0]    cls_q, cls_d;
  logic [HandleW-1:0] hdl_q, hdl_d;

  status_e            rstat_q, rstat_d;
  logic               rhv_q, rhv_d;
  logic [HandleW-1:0] rhout_q, rhout_d;
  logic [BytesW-1:0]  rbytes_q, rbytes_d;
  logic [ClsW-1:0]    rcls_q, rcls_d;
  logic               rcls_vld_q, rcls_vld_d;
  logic               rlim_q, rlim_d;

  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic               out_hv_q, out_hv_d;
  logic [HandleW-1:0] out_hout_q, out_hout_d;
  logic [BytesW-1:0]  out_bytes_q, out_bytes_d;
  logic [UsedW-1:0]   out_used_q, out_used_d;
  logic [CntW-1:0]    out_free_q, out_free_d;

  mem_req_t           req;
  logic [IdxW-1:0]    stk_rdata;
  logic               bm_rdata;

  logic [ClsW-1:0]    hc;
  logic [IdxW-1:0]    hi;
  logic               hc_ok;
  logic [CntW-1:0]    lim;
  logic [ClsW-1:0]    sel_cls;
  logic               sel_ok;
  logic [CntW-1:0]    depth_sel, wm_sel, dm1, free_sel;
  logic               allocated, take_pop, take_wm;
  logic               in_take, in_give, realloc_move;
  logic               accept, out_free, can_take;

  scba_store u_store (
    .clk_i       (clk_i),
    .req_i       (req),
    .stk_rdata_o (stk_rdata),
    .bm_rdata_o  (bm_rdata)
  );

  assign hc    = hdl_q[HandleW-1:IdxW];
  assign hi    = hdl_q[IdxW-1:0];
  assign hc_ok = hc < ClsW'(NumClasses);
  assign lim   = (cfg_q == '0 || cfg_q > LimitCap) ? LimitCap : cfg_q;

  // one class of the counter file is addressed per cycle
  always_comb begin
    case (state_q)
      S_EVAL:       sel_cls = (func_q == FUNC_ALLOC) ? cls_q : hc;
      S_TAKE, S_POP: sel_cls = cls_q;
      S_GIVE:       sel_cls = hc;
      S_RESP:       sel_cls = rcls_q;
      default:      sel_cls = hc;
    endcase
  end

  assign sel_ok    = sel_cls < ClsW'(NumClasses);
  assign depth_sel = sel_ok ? depth_q[sel_cls] : '0;
  assign wm_sel    = sel_ok ? wm_q[sel_cls] : '0;
  assign dm1       = depth_sel - 1'b1;
  assign free_sel  = depth_sel + ((lim > wm_sel) ? (lim - wm_sel) : '0);

  // flag read was issued at accept; valid in S_EVAL for handle-based ops
  assign allocated = hc_ok && ({1'b0, hi} < wm_sel) && bm_rdata;
  assign take_pop  = depth_sel != '0;
  assign take_wm   = wm_sel < lim;

  assign in_take = (state_q == S_EVAL && func_q == FUNC_ALLOC && !zero_q && !big_q)
                || state_q == S_TAKE;
  assign in_give = (state_q == S_EVAL && allocated
                    && (func_q == FUNC_FREE || (func_q == FUNC_REALLOC && zero_q)))
                || state_q == S_GIVE;
  assign realloc_move = state_q == S_EVAL && func_q == FUNC_REALLOC && allocated
                     && !zero_q && !big_q && cls_q != hc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign can_take   = state_q == S_IDLE || (state_q == S_RESP && out_free);
  assign in_stall_o = !can_take;
  assign accept     = in_valid_i && can_take;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (in_take)           state_d = take_pop ? S_POP : S_RESP;
        else if (realloc_move) state_d = S_TAKE;
        else                   state_d = S_RESP;
      end
      S_TAKE: begin
        if (take_pop)     state_d = S_POP;
        else if (take_wm) state_d = S_GIVE;
        else              state_d = S_RESP;
      end
      S_POP: begin
        state_d = (func_q == FUNC_REALLOC) ? S_GIVE : S_RESP;
      end
      S_GIVE: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = accept ? S_EVAL : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    depth_d    = depth_q;
    wm_d       = wm_q;
    used_d     = used_q;
    func_d     = func_q;
    zero_d     = zero_q;
    big_d      = big_q;
    cls_d      = cls_q;
    hdl_d      = hdl_q;
    rstat_d    = rstat_q;
    rhv_d      = rhv_q;
    rhout_d    = rhout_q;
    rbytes_d   = rbytes_q;
    rcls_d     = rcls_q;
    rcls_vld_d = rcls_vld_q;
    rlim_d     = rlim_q;
    req        = '0;

    if (accept) begin
      func_d      = in_func_i;
      zero_d      = in_request_size_i == '0;
      big_d       = in_request_size_i > MaxBytes;
      cls_d       = size_class(in_request_size_i);
      hdl_d       = in_handle_in_i;
      req.bm_re   = in_handle_in_i[HandleW-1:IdxW] < ClsW'(NumClasses);
      req.bm_raddr = in_handle_in_i;
    end

    if (state_q == S_EVAL) begin
      rstat_d    = ST_OK;
      rhv_d      = 1'b0;
      rhout_d    = '0;
      rbytes_d   = '0;
      rcls_d     = hc;
      rcls_vld_d = 1'b0;
      rlim_d     = 1'b0;
      case (func_q)
        FUNC_ALLOC: begin
          if (zero_q)     rstat_d = ST_ZERO;
          else if (big_q) rstat_d = ST_TOO_LARGE;
        end
        FUNC_FREE: begin
          if (!allocated) rstat_d = ST_BAD_HANDLE;
          else begin
            rbytes_d   = class_bytes(hc);
            rcls_vld_d = 1'b1;
          end
        end
        FUNC_QUERY: begin
          if (!allocated) rstat_d = ST_BAD_HANDLE;
          else begin
            rhv_d      = 1'b1;
            rhout_d    = hdl_q;
            rbytes_d   = class_bytes(hc);
            rcls_vld_d = 1'b1;
          end
        end
        FUNC_REALLOC: begin
          if (!allocated) rstat_d = ST_BAD_HANDLE;
          else if (zero_q) rcls_vld_d = 1'b1;
          else if (big_q) begin
            rstat_d    = ST_TOO_LARGE;
            rcls_vld_d = 1'b1;
          end else if (cls_q == hc) begin
            rhv_d      = 1'b1;
            rhout_d    = hdl_q;
            rbytes_d   = class_bytes(hc);
            rcls_vld_d = 1'b1;
          end
        end
        FUNC_RESET: begin
          for (int c = 0; c < NumClasses; c++) begin
            depth_d[c] = '0;
            wm_d[c]    = '0;
          end
          used_d = '0;
          rlim_d = 1'b1;
        end
        default: ;
      endcase
    end

    if (in_take) begin
      rcls_d     = cls_q;
      rcls_vld_d = 1'b1;
      rstat_d    = ST_OK;
      rhv_d      = 1'b0;
      rhout_d    = '0;
      rbytes_d   = '0;
      if (take_pop) begin
        if (sel_ok) depth_d[sel_cls] = dm1;
        req.stk_re    = 1'b1;
        req.stk_raddr = {cls_q, dm1[IdxW-1:0]};
        used_d        = used_q + UsedW'(class_bytes(cls_q));
        rhv_d         = 1'b1;
        rbytes_d      = class_bytes(cls_q);
      end else if (take_wm) begin
        if (sel_ok) wm_d[sel_cls] = wm_sel + 1'b1;
        req.bm_we    = 1'b1;
        req.bm_waddr = {cls_q, wm_sel[IdxW-1:0]};
        req.bm_wdata = 1'b1;
        used_d       = used_q + UsedW'(class_bytes(cls_q));
        rhv_d        = 1'b1;
        rhout_d      = {cls_q, wm_sel[IdxW-1:0]};
        rbytes_d     = class_bytes(cls_q);
      end else begin
        rstat_d = ST_EXHAUSTED;
      end
    end

    if (state_q == S_POP) begin
      rhout_d      = {cls_q, stk_rdata};
      req.bm_we    = 1'b1;
      req.bm_waddr = {cls_q, stk_rdata};
      req.bm_wdata = 1'b1;
    end

    if (in_give) begin
      if (depth_sel < CntW'(IdxSlots)) begin
        req.stk_we    = 1'b1;
        req.stk_waddr = {hc, depth_sel[IdxW-1:0]};
        req.stk_wdata = hi;
        if (sel_ok) depth_d[sel_cls] = depth_sel + 1'b1;
      end
      req.bm_we    = 1'b1;
      req.bm_waddr = hdl_q;
      req.bm_wdata = 1'b0;
      used_d       = used_q - UsedW'(class_bytes(hc));
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_hv_d     = out_hv_q;
    out_hout_d   = out_hout_q;
    out_bytes_d  = out_bytes_q;
    out_used_d   = out_used_q;
    out_free_d   = out_free_q;
    if (state_q == S_RESP && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = rstat_q;
      out_hv_d     = rhv_q;
      out_hout_d   = rhout_q;
      out_bytes_d  = rbytes_q;
      out_used_d   = used_q;
      out_free_d   = rcls_vld_q ? free_sel : (rlim_q ? lim : '0);
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= CntW'(64);
      used_q      <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NumClasses; c++) begin
        depth_q[c] <= '0;
        wm_q[c]    <= '0;
      end
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      depth_q     <= depth_d;
      wm_q        <= wm_d;
      if (cfg_valid_i && cfg_ready_o) cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    zero_q       <= zero_d;
    big_q        <= big_d;
    cls_q        <= cls_d;
    hdl_q        <= hdl_d;
    rstat_q      <= rstat_d;
    rhv_q        <= rhv_d;
    rhout_q      <= rhout_d;
    rbytes_q     <= rbytes_d;
    rcls_q       <= rcls_d;
    rcls_vld_q   <= rcls_vld_d;
    rlim_q       <= rlim_d;
    out_status_q <= out_status_d;
    out_hv_q     <= out_hv_d;
    out_hout_q   <= out_hout_d;
    out_bytes_q  <= out_bytes_d;
    out_used_q   <= out_used_d;
    out_free_q   <= out_free_d;
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_handle_valid_o = out_hv_q;
  assign out_handle_out_o   = out_hout_q;
  assign out_block_bytes_o  = out_bytes_q;
  assign out_bytes_in_use_o = out_used_q;
  assign out_class_free_o   = out_free_q;

  a_pop_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> $past(state_q) == S_EVAL || $past(state_q) == S_TAKE)
    else $error("stack pop without a take");

  a_reset_op_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL && func_q == FUNC_RESET |=> used_q == '0)
    else $error("bytes in use not cleared by reset op");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_RESP)
    else $error("result loaded outside response state");

  a_fail_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_o != ST_OK |-> !out_handle_valid_o && out_block_bytes_o == '0)
    else $error("failed transaction carries a handle");

  a_free_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESP && rcls_vld_q |-> free_sel <= LimitCap)
    else $error("class free count beyond limit");

endmodule
